>>> hw/rtl/pidc_pkg.sv
// ============================================================================
// PID controller package
// Shared widths, limits and register codes for the PID controller with
// integral clamp.
// ============================================================================
package pidc_pkg;

    typedef enum logic [1:0] {
        CFG_PROP_GAIN  = 2'd0,
        CFG_INTEG_GAIN = 2'd1,
        CFG_DERIV_GAIN = 2'd2,
        CFG_STEP_TIME  = 2'd3
    } cfg_index_t;

    localparam int GAIN_W  = 32;
    localparam int DT_W    = 25;
    localparam int DIV_N_W = 73;
    localparam int DIV_Q_W = 51;

    localparam logic [DT_W-1:0] DT_ONE     = 25'd16777216;
    localparam logic [DT_W-1:0] DT_DEFAULT = 25'd16777;

    localparam logic [DIV_Q_W-1:0] D_CAP = 51'h4_0000_0000_0000;

    localparam logic signed [35:0] SUM_MAX = 36'sd655360000;
    localparam logic signed [35:0] SUM_MIN = -36'sd655360000;
    localparam logic signed [31:0] INTEG_MAX = 32'sd655360000;
    localparam logic signed [31:0] INTEG_MIN = -32'sd655360000;

    localparam logic signed [52:0] TOT_MAX = 53'sd140737488355327;
    localparam logic signed [52:0] TOT_MIN = -53'sd140737488355328;

endpackage

>>> hw/rtl/pidc_smul.sv
// ============================================================================
// PID controller serial multiplier
// Signed shift-add multiplier that takes one bit of the b operand per cycle,
// lowest bit first, and subtracts on the sign bit.
// ============================================================================
module pidc_smul #(
    parameter int AW = 32,
    parameter int BW = 33
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [AW-1:0]     a,
    input  logic signed [BW-1:0]     b,
    output logic                     busy,
    output logic signed [AW+BW-1:0]  prod
);

    localparam int CNT_W = $clog2(BW + 1);

    logic                busy_reg, busy_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic signed [AW-1:0] a_reg, a_next;
    logic [BW-1:0]       b_reg, b_next;
    logic signed [AW:0]  hi_reg, hi_next;
    logic [BW-1:0]       lo_reg, lo_next;

    logic signed [AW+1:0] a_ext;
    logic signed [AW+1:0] hi_ext;
    logic signed [AW+1:0] sum;
    logic                 last_bit;

    always_comb begin
        a_ext    = (AW+2)'(a_reg);
        hi_ext   = (AW+2)'(hi_reg);
        last_bit = (cnt_reg == CNT_W'(1));
        if (b_reg[0]) begin
            sum = last_bit ? (hi_ext - a_ext) : (hi_ext + a_ext);
        end else begin
            sum = hi_ext;
        end

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;

        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(BW);
            a_next    = a;
            b_next    = b;
            hi_next   = '0;
            lo_next   = '0;
        end else if (busy_reg) begin
            hi_next  = sum[AW+1:1];
            lo_next  = {sum[0], lo_reg[BW-1:1]};
            b_next   = {1'b0, b_reg[BW-1:1]};
            cnt_next = cnt_reg - CNT_W'(1);
            if (last_bit) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        a_reg  <= a_next;
        b_reg  <= b_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign busy = busy_reg;
    assign prod = {hi_reg[AW-1:0], lo_reg};

endmodule

>>> hw/rtl/pidc_sdiv.sv
// ============================================================================
// PID controller serial divider
// Restoring divider that produces one quotient bit per cycle and caps the
// quotient at two to the fiftieth.
// ============================================================================
module pidc_sdiv (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [pidc_pkg::DIV_N_W-1:0]     num,
    input  logic [pidc_pkg::DT_W-1:0]        den,
    output logic                             busy,
    output logic [pidc_pkg::DIV_Q_W-1:0]     quot
);

    localparam int NW    = pidc_pkg::DIV_N_W;
    localparam int DW    = pidc_pkg::DT_W;
    localparam int QW    = pidc_pkg::DIV_Q_W;
    localparam int CNT_W = $clog2(NW + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NW-1:0]    num_reg, num_next;
    logic [DW-1:0]    den_reg, den_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [QW-1:0]    q_reg, q_next;
    logic             cap_reg, cap_next;

    logic [DW:0] trial;
    logic        fits;

    always_comb begin
        trial = {rem_reg, num_reg[NW-1]};
        fits  = (trial >= {1'b0, den_reg});

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        cap_next  = cap_reg;

        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NW);
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            q_next    = '0;
            cap_next  = 1'b0;
        end else if (busy_reg) begin
            rem_next = fits ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
            q_next   = {q_reg[QW-2:0], fits};
            cap_next = cap_reg | q_reg[QW-1];
            num_next = {num_reg[NW-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        cap_reg <= cap_next;
    end

    assign busy = busy_reg;
    assign quot = (cap_reg || q_reg[QW-1]) ? pidc_pkg::D_CAP : q_reg;

endmodule

>>> hw/rtl/pid_controller_antiwindup_unit.sv
// ============================================================================
// PID controller with integral clamp
// Fixed-point PID controller: P, I and D terms formed by serial multipliers
// and a serial divider, integral held to +/-10000, output saturated to 48 bits.
// ============================================================================
//
// Channel   Direction  Contents
// s_*       in         tdata: setpoint [31:0], measured [63:32]; tuser: clear
// m_*       out        tdata: drive [47:0]
// cfg_*     in         register index and write data
//
// A sample's result is registered at the end of its run, and the controller
// then returns to idle to take the next sample. Most of that run is spent in
// the serial divider for the derivative term, after the serial multipliers.
// A clear transaction skips the arithmetic and goes straight to the result.
// Input is taken only while the controller is idle; the result register lets
// the next sample be accepted while the previous result waits for m_tready.
// aresetn is synchronous and clears the state, gains and the output valid.
//
module pid_controller_antiwindup_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // setpoint [31:0], measured [63:32]
    input  logic        s_tuser,   // clear_state [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // drive [47:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START1,
        S_MUL1,
        S_STEP2,
        S_MUL2,
        S_FIN
    } state_t;

    state_t state_reg, state_next;

    logic signed [31:0] prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic [pidc_pkg::DT_W-1:0] step_time_reg;

    logic signed [32:0] err_reg, err_next;
    logic signed [32:0] last_error_reg, last_error_next;
    logic signed [31:0] integ_sum_reg, integ_sum_next;
    logic [pidc_pkg::DT_W-1:0] dt_reg, dt_next;
    logic signed [48:0] pterm_reg, pterm_next;
    logic signed [49:0] acc_reg, acc_next;
    logic signed [51:0] dterm_reg, dterm_next;
    logic               dneg_reg, dneg_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [47:0]        m_tdata_reg, m_tdata_next;

    logic signed [31:0] s_setpoint, s_measured;

    logic               mul_pi_start, mul_pi_busy;
    logic signed [31:0] mul_pi_a;
    logic signed [32:0] mul_pi_b;
    logic signed [64:0] mul_pi_prod;

    logic               mul_inc_start, mul_inc_busy;
    logic signed [25:0] mul_inc_b;
    logic signed [58:0] mul_inc_prod;

    logic               mul_d_start, mul_d_busy;
    logic signed [33:0] diff;
    logic signed [65:0] mul_d_prod;

    logic                               div_start, div_busy;
    logic [pidc_pkg::DIV_N_W-1:0]       div_num;
    logic [pidc_pkg::DIV_Q_W-1:0]       div_quot;

    logic signed [34:0] inc;
    logic signed [35:0] sum_raw;
    logic signed [31:0] sum_clamped;
    logic [65:0]        d_mag;
    logic signed [52:0] total;

    assign s_setpoint = s_tdata[31:0];
    assign s_measured = s_tdata[63:32];
    assign cfg_ready  = 1'b1;

    assign mul_inc_b = {1'b0, dt_reg};
    assign diff      = 34'(err_reg) - 34'(last_error_reg);
    assign inc       = mul_inc_prod[58:24];
    assign sum_raw   = 36'(integ_sum_reg) + 36'(inc);
    assign d_mag     = mul_d_prod[65] ? (66'd0 - mul_d_prod) : mul_d_prod;
    assign div_num   = {d_mag[64:0], 8'h00};
    assign total     = 53'(acc_reg) + 53'(dterm_reg);

    always_comb begin
        priority if (sum_raw > pidc_pkg::SUM_MAX) begin
            sum_clamped = pidc_pkg::INTEG_MAX;
        end else if (sum_raw < pidc_pkg::SUM_MIN) begin
            sum_clamped = pidc_pkg::INTEG_MIN;
        end else begin
            sum_clamped = sum_raw[31:0];
        end
    end

    pidc_smul #(.AW(32), .BW(33)) u_mul_pi (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_pi_start),
        .a       (mul_pi_a),
        .b       (mul_pi_b),
        .busy    (mul_pi_busy),
        .prod    (mul_pi_prod)
    );

    pidc_smul #(.AW(33), .BW(26)) u_mul_inc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_inc_start),
        .a       (err_reg),
        .b       (mul_inc_b),
        .busy    (mul_inc_busy),
        .prod    (mul_inc_prod)
    );

    pidc_smul #(.AW(32), .BW(34)) u_mul_d (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_d_start),
        .a       (deriv_gain_reg),
        .b       (diff),
        .busy    (mul_d_busy),
        .prod    (mul_d_prod)
    );

    pidc_sdiv u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (dt_reg),
        .busy    (div_busy),
        .quot    (div_quot)
    );

    always_comb begin
        state_next      = state_reg;
        err_next        = err_reg;
        last_error_next = last_error_reg;
        integ_sum_next  = integ_sum_reg;
        dt_next         = dt_reg;
        pterm_next      = pterm_reg;
        acc_next        = acc_reg;
        dterm_next      = dterm_reg;
        dneg_next       = dneg_reg;
        m_tvalid_next   = m_tvalid_reg & ~m_tready;
        m_tdata_next    = m_tdata_reg;
        mul_pi_start    = 1'b0;
        mul_inc_start   = 1'b0;
        mul_d_start     = 1'b0;
        div_start       = 1'b0;
        mul_pi_a        = prop_gain_reg;
        mul_pi_b        = err_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    err_next = 33'(s_setpoint) - 33'(s_measured);
                    if (step_time_reg == '0 || step_time_reg > pidc_pkg::DT_ONE) begin
                        dt_next = pidc_pkg::DT_DEFAULT;
                    end else begin
                        dt_next = step_time_reg;
                    end
                    if (s_tuser) begin
                        integ_sum_next  = '0;
                        last_error_next = '0;
                        acc_next        = '0;
                        dterm_next      = '0;
                        state_next      = S_FIN;
                    end else begin
                        state_next = S_START1;
                    end
                end
            end
            S_START1: begin
                mul_pi_start  = 1'b1;
                mul_inc_start = 1'b1;
                mul_d_start   = 1'b1;
                state_next    = S_MUL1;
            end
            S_MUL1: begin
                if (!mul_pi_busy && !mul_inc_busy && !mul_d_busy) begin
                    state_next = S_STEP2;
                end
            end
            S_STEP2: begin
                pterm_next      = mul_pi_prod[64:16];
                integ_sum_next  = sum_clamped;
                last_error_next = err_reg;
                mul_pi_a        = integ_gain_reg;
                mul_pi_b        = 33'(sum_clamped);
                mul_pi_start    = 1'b1;
                dneg_next       = mul_d_prod[65];
                div_start       = 1'b1;
                state_next      = S_MUL2;
            end
            S_MUL2: begin
                if (!mul_pi_busy && !div_busy) begin
                    acc_next   = 50'(pterm_reg) + 50'($signed(mul_pi_prod[64:16]));
                    dterm_next = dneg_reg ? (52'sd0 - 52'({1'b0, div_quot}))
                                          : 52'({1'b0, div_quot});
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    priority if (total > pidc_pkg::TOT_MAX) begin
                        m_tdata_next = pidc_pkg::TOT_MAX[47:0];
                    end else if (total < pidc_pkg::TOT_MIN) begin
                        m_tdata_next = pidc_pkg::TOT_MIN[47:0];
                    end else begin
                        m_tdata_next = total[47:0];
                    end
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_tvalid_reg   <= 1'b0;
            integ_sum_reg  <= '0;
            last_error_reg <= '0;
            prop_gain_reg  <= '0;
            integ_gain_reg <= '0;
            deriv_gain_reg <= '0;
            step_time_reg  <= pidc_pkg::DT_DEFAULT;
        end else begin
            state_reg      <= state_next;
            m_tvalid_reg   <= m_tvalid_next;
            integ_sum_reg  <= integ_sum_next;
            last_error_reg <= last_error_next;
            if (cfg_valid && cfg_ready) begin
                unique case (pidc_pkg::cfg_index_t'(cfg_index))
                    pidc_pkg::CFG_PROP_GAIN:  prop_gain_reg  <= cfg_data;
                    pidc_pkg::CFG_INTEG_GAIN: integ_gain_reg <= cfg_data;
                    pidc_pkg::CFG_DERIV_GAIN: deriv_gain_reg <= cfg_data;
                    pidc_pkg::CFG_STEP_TIME:  step_time_reg  <= cfg_data[pidc_pkg::DT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        err_reg     <= err_next;
        dt_reg      <= dt_next;
        pterm_reg   <= pterm_next;
        acc_reg     <= acc_next;
        dterm_reg   <= dterm_next;
        dneg_reg    <= dneg_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The stored integral never leaves the clamp range.
    a_integ_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (integ_sum_reg <= pidc_pkg::INTEG_MAX) && (integ_sum_reg >= pidc_pkg::INTEG_MIN))
        else $error("integral outside clamp range");

    // A clear transaction zeroes the controller state by the next cycle.
    a_clear_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser) |=> (integ_sum_reg == '0) && (last_error_reg == '0))
        else $error("state not cleared");

    // No arithmetic unit is still running while the controller is idle.
    a_idle_units: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !(mul_pi_busy || mul_inc_busy || mul_d_busy || div_busy))
        else $error("arithmetic unit busy while idle");

    // A finished result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> m_tvalid_reg && $stable(m_tdata_reg))
        else $error("pending result overwritten");

endmodule

>>> sim/pid_controller_antiwindup_unit_test.sv
`timescale 1ns / 100ps
// ============================================================================
// PID controller with integral clamp: self-checking testbench
// A driver feeds samples from a backlog onto the input stream, and a monitor
// compares each drive value against a predictor that tracks the integral,
// the previous error and the gain registers. Gains and step time are
// reprogrammed between phases while the controller is idle.
// ============================================================================
module pid_controller_antiwindup_unit_test;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 150;

    typedef struct packed {
        logic signed [31:0] setpoint;
        logic signed [31:0] measured;
        logic               clear;
    } sample_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    pidc_pkg::cfg_index_t cfg_index = pidc_pkg::CFG_PROP_GAIN;
    logic [31:0] cfg_data = '0;

    sample_t            sample_backlog[$];
    logic [47:0]        pending_drive[$];
    sample_t            held_sample;
    logic               throttle_on = 1'b1;
    int                 src_gap = 0;
    int                 sink_gap = 0;
    int                 cycle_count = 0;
    int                 failures = 0;
    int                 samples_taken = 0;
    int                 clears_taken = 0;
    int                 drives_checked = 0;
    int                 reg_writes = 0;

    logic signed [31:0] gain_p;
    logic signed [31:0] gain_i;
    logic signed [31:0] gain_d;
    logic [24:0]        step_reg;
    logic signed [31:0] integ_acc;
    logic signed [32:0] prev_error;

    pid_controller_antiwindup_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [47:0] next_drive(input logic signed [31:0] setpoint,
                                               input logic signed [31:0] measured,
                                               input logic clear);
        logic signed [79:0] e, last, kp_w, ki_w, kd_w, dt_w, inc, sum, diff;
        logic signed [79:0] p_t, i_t, d_t, total;
        logic [79:0]        kd_mag, diff_mag, d_mag;
        logic [24:0]        dt;
        if (clear) begin
            integ_acc = '0;
            prev_error = '0;
            return 48'd0;
        end
        dt = (step_reg == '0 || step_reg > pidc_pkg::DT_ONE) ? pidc_pkg::DT_DEFAULT
                                                              : step_reg;
        e = setpoint - measured;
        last = prev_error;
        kp_w = gain_p;
        ki_w = gain_i;
        kd_w = gain_d;
        dt_w = dt;
        p_t = (kp_w * e) >>> 16;
        inc = (e * dt_w) >>> 24;
        sum = integ_acc + inc;
        if (sum > pidc_pkg::INTEG_MAX) begin
            sum = pidc_pkg::INTEG_MAX;
        end else if (sum < pidc_pkg::INTEG_MIN) begin
            sum = pidc_pkg::INTEG_MIN;
        end
        integ_acc = sum[31:0];
        i_t = (ki_w * sum) >>> 16;
        diff = e - last;
        kd_mag = (kd_w < 0) ? -kd_w : kd_w;
        diff_mag = (diff < 0) ? -diff : diff;
        d_mag = (kd_mag * diff_mag * 80'd256) / dt;
        if (d_mag > pidc_pkg::D_CAP) begin
            d_mag = pidc_pkg::D_CAP;
        end
        d_t = ((kd_w < 0) != (diff < 0)) ? -$signed(d_mag) : $signed(d_mag);
        prev_error = e[32:0];
        total = p_t + i_t + d_t;
        if (total > pidc_pkg::TOT_MAX) begin
            total = pidc_pkg::TOT_MAX;
        end else if (total < pidc_pkg::TOT_MIN) begin
            total = pidc_pkg::TOT_MIN;
        end
        return total[47:0];
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                pending_drive.push_back(next_drive(held_sample.setpoint,
                                                   held_sample.measured,
                                                   held_sample.clear));
                samples_taken++;
                if (held_sample.clear) begin
                    clears_taken++;
                end
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap != 0) begin
                    src_gap <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (throttle_on && $urandom_range(0, 4) == 0) begin
                    src_gap <= $urandom_range(0, 6);
                    s_tvalid <= 1'b0;
                end else if (sample_backlog.size() != 0) begin
                    held_sample = sample_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {held_sample.measured, held_sample.setpoint};
                    s_tuser <= held_sample.clear;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_gap <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_drive.size() == 0) begin
                    $display("%0t: unexpected drive transaction, expected none, got %h",
                             $time, m_tdata);
                    failures++;
                end else begin
                    if (m_tdata !== pending_drive[0]) begin
                        $display("%0t: drive mismatch, expected %h, got %h",
                                 $time, pending_drive[0], m_tdata);
                        failures++;
                    end
                    void'(pending_drive.pop_front());
                    drives_checked++;
                end
            end
            if (sink_gap != 0) begin
                sink_gap <= sink_gap - 1;
                m_tready <= 1'b0;
            end else if (throttle_on && $urandom_range(0, 4) == 0) begin
                sink_gap <= $urandom_range(0, 6);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d drive values outstanding.",
                     cycle_count, pending_drive.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic queue_sample(input logic [31:0] setpoint, input logic [31:0] measured,
                                input logic clear);
        sample_t s;
        s.setpoint = setpoint;
        s.measured = measured;
        s.clear = clear;
        sample_backlog.push_back(s);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        while (sample_backlog.size() != 0 || s_tvalid || pending_drive.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic write_reg(input pidc_pkg::cfg_index_t idx, input logic [31:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            pidc_pkg::CFG_PROP_GAIN:  gain_p = value;
            pidc_pkg::CFG_INTEG_GAIN: gain_i = value;
            pidc_pkg::CFG_DERIV_GAIN: gain_d = value;
            pidc_pkg::CFG_STEP_TIME:  step_reg = value[24:0];
        endcase
    endtask

    task automatic load_settings(input logic [31:0] kp, input logic [31:0] ki,
                                 input logic [31:0] kd, input logic [31:0] step);
        wait_idle();
        write_reg(pidc_pkg::CFG_PROP_GAIN, kp);
        write_reg(pidc_pkg::CFG_INTEG_GAIN, ki);
        write_reg(pidc_pkg::CFG_DERIV_GAIN, kd);
        write_reg(pidc_pkg::CFG_STEP_TIME, step);
    endtask

    function automatic logic [31:0] rand_gain();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($urandom_range(0, 32'h0000_2000));
        endcase
    endfunction

    function automatic logic [31:0] rand_step();
        logic [24:0] v;
        case ($urandom_range(0, 5))
            0: v = 25'($urandom_range(1, 32'h0100_0000));
            1: v = 25'($urandom_range(1, 2000));
            2: v = pidc_pkg::DT_DEFAULT;
            3: v = '0;
            4: v = 25'($urandom_range(32'h0100_0001, 32'h01FF_FFFF));
            default: v = pidc_pkg::DT_ONE;
        endcase
        return {7'($urandom), v};
    endfunction

    function automatic logic [31:0] rand_level();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
        endcase
    endfunction

    initial begin
        int target;
        int plant;
        int pick;
        gain_p = '0;
        gain_i = '0;
        gain_d = '0;
        step_reg = pidc_pkg::DT_DEFAULT;
        integ_acc = '0;
        prev_error = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        queue_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        queue_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        queue_sample(32'h0000_0000, 32'h0000_0000, 1'b1);

        load_settings(32'h0001_0000, 32'h0000_8000, 32'h0000_0100,
                      {7'h00, pidc_pkg::DT_ONE});
        queue_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        queue_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        queue_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        queue_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        queue_sample(32'h0000_0000, 32'h0000_0000, 1'b0);
        queue_sample(32'h1234_5678, 32'h1234_5678, 1'b0);
        queue_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        queue_sample(32'h0000_0001, 32'h0000_0000, 1'b0);
        queue_sample(32'h0000_0000, 32'h0000_0001, 1'b0);
        queue_sample(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);

        load_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        queue_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        queue_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        queue_sample(32'h0000_0000, 32'h0000_0000, 1'b0);
        queue_sample(32'h0000_0000, 32'h0000_0000, 1'b1);
        queue_sample(32'h0000_0005, 32'h0000_0005, 1'b0);

        load_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        queue_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        queue_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        queue_sample(32'h0001_0000, 32'h0000_0000, 1'b0);

        load_settings(32'h0002_0000, 32'hFFFF_0000, 32'h0000_4000, 32'h0100_0001);
        queue_sample(32'h0010_0000, 32'h0000_0000, 1'b0);
        queue_sample(32'hFFF0_0000, 32'h0000_0000, 1'b0);
        wait_idle();
        write_reg(pidc_pkg::CFG_STEP_TIME, 32'hFFFF_FFFF);
        queue_sample(32'h0010_0000, 32'h0008_0000, 1'b0);
        queue_sample(32'h8000_0000, 32'h0000_0000, 1'b0);

        for (int phase = 0; phase < 8; phase++) begin
            wait_idle();
            throttle_on = (phase != 3 && phase != 7);
            load_settings(rand_gain(), rand_gain(), rand_gain(), rand_step());
            target = int'(rand_level());
            plant = 0;
            for (int n = 0; n < 86; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    queue_sample($urandom, $urandom, 1'b1);
                    plant = 0;
                end else if (pick < 16) begin
                    queue_sample($urandom, $urandom, 1'b0);
                end else begin
                    if ($urandom_range(0, 19) == 0) begin
                        target = int'(rand_level());
                    end
                    plant = plant + ((target - plant) >>> 3)
                            + int'($urandom_range(0, 2048)) - 1024;
                    queue_sample(target, plant, 1'b0);
                end
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Run covered %0d samples (%0d clear transactions) and %0d register writes.",
                 samples_taken, clears_taken, reg_writes);
        $display("%0d drive values were compared, with %0d mismatches.",
                 drives_checked, failures);
        if (failures == 0 && pending_drive.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
